>>> hw/rtl/keypad_scan_servo_select_core_assert.svh
// ----------------------------------------------------------------------------
// Keypad scanner assertion macros
// Shorthand for the concurrent checks used in the keypad scanner top level.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_SCAN_SERVO_SELECT_CORE_ASSERT_SVH
`define KEYPAD_SCAN_SERVO_SELECT_CORE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define KSS_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("keypad scanner check failed");

// A condition that must hold in the cycle after a trigger.
`define KSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keypad scanner sequence check failed");

`endif

>>> hw/rtl/kss_pkg.sv
// ----------------------------------------------------------------------------
// Keypad scanner package
// Types, register map and constants shared by the keypad scanner modules.
// ----------------------------------------------------------------------------
package kss_pkg;

  localparam int TICK_CNT_W = 16;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef logic [TICK_CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_SCAN     = 2'd2,
    PH_HOLD     = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    REG_DEBOUNCE = 3'd0,
    REG_HOLD     = 3'd1,
    REG_POS_A    = 3'd2,
    REG_POS_B    = 3'd3,
    REG_POS_C    = 3'd4,
    REG_FADE_TOP = 3'd5
  } reg_idx_t;

  localparam logic [15:0] DEBOUNCE_RST = 16'd10;
  localparam logic [15:0] HOLD_RST     = 16'd1000;
  localparam logic [15:0] POS_A_RST    = 16'd500;
  localparam logic [15:0] POS_B_RST    = 16'd1500;
  localparam logic [15:0] POS_C_RST    = 16'd2500;
  localparam logic [9:0]  FADE_TOP_RST = 10'd999;
  localparam logic [15:0] SERVO_RST    = 16'd4999;
  localparam logic [9:0]  LED_RST      = 10'd500;
  localparam logic [9:0]  BRIGHT_RST   = 10'd1;

  localparam logic [3:0] COLS_NONE = 4'hF;
  localparam logic [3:0] ROWS_ALL_LOW = 4'h0;
  localparam logic [3:0] ROWS_ALL_HIGH = 4'hF;
  localparam logic [3:0] ROWS_LAST_SCAN = 4'b0111;
  localparam logic [1:0] LAST_ROW = 2'd3;

  localparam logic [3:0] KEY_A = 4'd3;
  localparam logic [3:0] KEY_B = 4'd7;
  localparam logic [3:0] KEY_C = 4'd11;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [15:0] hold_ticks;
    logic [15:0] servo_pos_a;
    logic [15:0] servo_pos_b;
    logic [15:0] servo_pos_c;
    logic [9:0]  fade_top;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  row_drive;
    logic [15:0] servo_compare;
    logic [9:0]  led_compare;
    logic        key_valid;
    logic [3:0]  key_index;
  } res_t;

  typedef struct packed {
    logic out_valid;
    logic out_ready;
  } out_status_t;

endpackage

>>> hw/rtl/kss_stream_if.sv
// ----------------------------------------------------------------------------
// Keypad scanner stream interfaces
// Valid/ready channels for column samples in and scan results out.
// ----------------------------------------------------------------------------
interface kss_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] column_lines;

  modport source (output valid, output column_lines, input ready);
  modport sink (input valid, input column_lines, output ready);
endinterface

interface kss_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  row_drive;
  logic [15:0] servo_compare;
  logic [9:0]  led_compare;
  logic        key_valid;
  logic [3:0]  key_index;

  modport source (output valid, output row_drive, output servo_compare,
                  output led_compare, output key_valid, output key_index,
                  input ready);
  modport sink (input valid, input row_drive, input servo_compare,
                input led_compare, input key_valid, input key_index,
                output ready);
endinterface

>>> hw/rtl/kss_cfg_regs.sv
// ----------------------------------------------------------------------------
// Keypad scanner configuration registers
// APB-style register file holding debounce, hold, servo and fade settings.
// ----------------------------------------------------------------------------
module kss_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [kss_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [kss_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [kss_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output kss_pkg::cfg_t                    cfg
);

  kss_pkg::cfg_t cfg_r;
  logic [2:0]    idx;
  logic          wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks <= kss_pkg::DEBOUNCE_RST;
      cfg_r.hold_ticks     <= kss_pkg::HOLD_RST;
      cfg_r.servo_pos_a    <= kss_pkg::POS_A_RST;
      cfg_r.servo_pos_b    <= kss_pkg::POS_B_RST;
      cfg_r.servo_pos_c    <= kss_pkg::POS_C_RST;
      cfg_r.fade_top       <= kss_pkg::FADE_TOP_RST;
    end else if (wr_en) begin
      case (idx)
        kss_pkg::REG_DEBOUNCE: cfg_r.debounce_ticks <= pwdata[15:0];
        kss_pkg::REG_HOLD:     cfg_r.hold_ticks     <= pwdata[15:0];
        kss_pkg::REG_POS_A:    cfg_r.servo_pos_a    <= pwdata[15:0];
        kss_pkg::REG_POS_B:    cfg_r.servo_pos_b    <= pwdata[15:0];
        kss_pkg::REG_POS_C:    cfg_r.servo_pos_c    <= pwdata[15:0];
        kss_pkg::REG_FADE_TOP: cfg_r.fade_top       <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      kss_pkg::REG_DEBOUNCE: prdata = {16'd0, cfg_r.debounce_ticks};
      kss_pkg::REG_HOLD:     prdata = {16'd0, cfg_r.hold_ticks};
      kss_pkg::REG_POS_A:    prdata = {16'd0, cfg_r.servo_pos_a};
      kss_pkg::REG_POS_B:    prdata = {16'd0, cfg_r.servo_pos_b};
      kss_pkg::REG_POS_C:    prdata = {16'd0, cfg_r.servo_pos_c};
      kss_pkg::REG_FADE_TOP: prdata = {22'd0, cfg_r.fade_top};
      default:               prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/kss_scan_engine.sv
// ----------------------------------------------------------------------------
// Keypad scanner engine
// Scan state machine, key decode, servo select and LED fade, one tick a request.
// ----------------------------------------------------------------------------
module kss_scan_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic [3:0]    column_lines,
  input  kss_pkg::cfg_t cfg,
  output kss_pkg::res_t res
);

  kss_pkg::phase_t phase_r, phase_nxt;
  kss_pkg::cnt_t   cnt_r, cnt_nxt;
  logic [1:0]      col_r, col_nxt;
  logic [1:0]      prow_r, prow_nxt;
  logic [1:0]      srow_r, srow_nxt;
  logic [9:0]      bright_r, bright_nxt;
  logic            rising_r, rising_nxt;
  logic [15:0]     servo_r, servo_nxt;
  logic [9:0]      led_r, led_nxt;

  kss_pkg::cnt_t   deb_cnt, hold_cnt, cnt_dec;
  logic [3:0]      low_cols;
  logic [1:0]      hi_col;
  logic            col_hit;
  logic [1:0]      prow_scan;
  logic [3:0]      key;
  logic            servo_key;
  logic            last_row;
  logic            fade_turn;
  logic            rising_step;

  assign deb_cnt   = kss_pkg::TICK_CNT_W'(cfg.debounce_ticks);
  assign hold_cnt  = kss_pkg::TICK_CNT_W'(cfg.hold_ticks);
  assign cnt_dec   = (cnt_r != '0) ? cnt_r - 1'b1 : cnt_r;
  assign low_cols  = ~column_lines;
  // The highest-numbered low column wins.
  assign hi_col    = low_cols[3] ? 2'd3 : low_cols[2] ? 2'd2 : low_cols[1] ? 2'd1 : 2'd0;
  assign col_hit   = !column_lines[col_r];
  assign prow_scan = col_hit ? srow_r : prow_r;
  assign key       = {prow_scan, col_r};
  assign servo_key = (key == kss_pkg::KEY_A) || (key == kss_pkg::KEY_B) ||
                     (key == kss_pkg::KEY_C);
  assign last_row  = (srow_r == kss_pkg::LAST_ROW);
  assign fade_turn = (bright_r >= cfg.fade_top) || (bright_r == '0);
  assign rising_step = rising_r ^ fade_turn;

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      kss_pkg::PH_IDLE: begin
        if (column_lines != kss_pkg::COLS_NONE) begin
          phase_nxt = (deb_cnt == '0) ? kss_pkg::PH_SCAN : kss_pkg::PH_DEBOUNCE;
        end
      end
      kss_pkg::PH_DEBOUNCE: begin
        if (cnt_dec == '0) begin
          phase_nxt = kss_pkg::PH_SCAN;
        end
      end
      kss_pkg::PH_SCAN: begin
        if (last_row) begin
          phase_nxt = (servo_key && hold_cnt != '0) ? kss_pkg::PH_HOLD : kss_pkg::PH_IDLE;
        end
      end
      kss_pkg::PH_HOLD: begin
        if (cnt_dec == '0) begin
          phase_nxt = kss_pkg::PH_IDLE;
        end
      end
      default: phase_nxt = kss_pkg::PH_IDLE;
    endcase
  end

  // Datapath and result fields.
  always_comb begin
    cnt_nxt    = cnt_r;
    col_nxt    = col_r;
    prow_nxt   = prow_r;
    srow_nxt   = srow_r;
    bright_nxt = bright_r;
    rising_nxt = rising_r;
    servo_nxt  = servo_r;
    led_nxt    = led_r;
    res.row_drive = kss_pkg::ROWS_ALL_LOW;
    res.key_valid = 1'b0;
    res.key_index = 4'd0;
    case (phase_r)
      kss_pkg::PH_IDLE: begin
        if (column_lines != kss_pkg::COLS_NONE) begin
          col_nxt  = hi_col;
          cnt_nxt  = deb_cnt;
          srow_nxt = 2'd0;
        end
      end
      kss_pkg::PH_DEBOUNCE: begin
        cnt_nxt = cnt_dec;
        if (cnt_dec == '0) begin
          srow_nxt = 2'd0;
        end
      end
      kss_pkg::PH_SCAN: begin
        res.row_drive = ~(4'd1 << srow_r);
        prow_nxt = prow_scan;
        if (last_row) begin
          srow_nxt      = 2'd0;
          res.key_valid = 1'b1;
          res.key_index = key;
          if (key == kss_pkg::KEY_A) begin
            servo_nxt = cfg.servo_pos_a;
          end else if (key == kss_pkg::KEY_B) begin
            servo_nxt = cfg.servo_pos_b;
          end else if (key == kss_pkg::KEY_C) begin
            servo_nxt = cfg.servo_pos_c;
          end
          if (servo_key) begin
            cnt_nxt = hold_cnt;
          end
          rising_nxt = rising_step;
          bright_nxt = rising_step ? bright_r + 10'd1 : bright_r - 10'd1;
          led_nxt    = bright_nxt;
        end else begin
          srow_nxt = srow_r + 2'd1;
        end
      end
      kss_pkg::PH_HOLD: begin
        res.row_drive = kss_pkg::ROWS_ALL_HIGH;
        cnt_nxt = cnt_dec;
      end
      default: ;
    endcase
    res.servo_compare = servo_nxt;
    res.led_compare   = led_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= kss_pkg::PH_IDLE;
      cnt_r    <= '0;
      col_r    <= 2'd0;
      prow_r   <= 2'd0;
      srow_r   <= 2'd0;
      bright_r <= kss_pkg::BRIGHT_RST;
      rising_r <= 1'b1;
      servo_r  <= kss_pkg::SERVO_RST;
      led_r    <= kss_pkg::LED_RST;
    end else if (step) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      col_r    <= col_nxt;
      prow_r   <= prow_nxt;
      srow_r   <= srow_nxt;
      bright_r <= bright_nxt;
      rising_r <= rising_nxt;
      servo_r  <= servo_nxt;
      led_r    <= led_nxt;
    end
  end

endmodule

>>> hw/rtl/kss_out_reg.sv
// ----------------------------------------------------------------------------
// Keypad scanner result register
// Holds one result until the sink takes it, so input and output stay decoupled.
// ----------------------------------------------------------------------------
module kss_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  kss_pkg::res_t        res,
  output kss_pkg::out_status_t status,
  kss_out_if.source            out_ch
);

  logic          valid_r, valid_nxt;
  kss_pkg::res_t data_r;

  assign status.out_valid = valid_r;
  assign status.out_ready = out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.row_drive     = data_r.row_drive;
  assign out_ch.servo_compare = data_r.servo_compare;
  assign out_ch.led_compare   = data_r.led_compare;
  assign out_ch.key_valid     = data_r.key_valid;
  assign out_ch.key_index     = data_r.key_index;

endmodule

>>> hw/rtl/keypad_scan_servo_select_core.sv
// ----------------------------------------------------------------------------
// Keypad scan servo select core
// Output: a result appears on the output in the cycle after its tick is accepted.
// Throughput: one tick per cycle; the input stalls only while a result waits.
// Reset: synchronous, active low; no clearing pass, ready from the first cycle.
// ----------------------------------------------------------------------------
`include "keypad_scan_servo_select_core_assert.svh"

module keypad_scan_servo_select_core (
  input  logic                           clk,
  input  logic                           rst_n,
  kss_in_if.sink                         in_ch,
  kss_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [kss_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [kss_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [kss_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  kss_pkg::cfg_t        cfg;
  kss_pkg::res_t        res;
  kss_pkg::out_status_t status;
  logic                 fire;

  // A new request is taken whenever the result register is empty or draining.
  assign in_ch.ready = !status.out_valid || status.out_ready;
  assign fire        = in_ch.valid && in_ch.ready;

  kss_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kss_scan_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (fire),
    .column_lines (in_ch.column_lines),
    .cfg          (cfg),
    .res          (res)
  );

  kss_out_reg u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (fire),
    .res    (res),
    .status (status),
    .out_ch (out_ch)
  );

  `KSS_ASSERT_NEXT(a_fire_gives_result, clk, rst_n, fire, out_ch.valid)
  `KSS_ASSERT_ALWAYS(a_stall_blocks_input, clk, rst_n,
                     !(out_ch.valid && !out_ch.ready) || !in_ch.ready)
  `KSS_ASSERT_ALWAYS(a_decode_on_last_row, clk, rst_n,
                     !(out_ch.valid && out_ch.key_valid) ||
                     (out_ch.row_drive == kss_pkg::ROWS_LAST_SCAN))
  `KSS_ASSERT_ALWAYS(a_no_key_no_index, clk, rst_n,
                     !(out_ch.valid && !out_ch.key_valid) || (out_ch.key_index == 4'd0))

endmodule
